### rtl/xcrc_pkg.sv
// ============================================================================
// xcrc_pkg: shared types and constants for the XMODEM-CRC receiver
// Holds the protocol byte codes, the event and result encodings, the
// transfer structs exchanged between the stages, and the CRC-16 byte update.
// ============================================================================
`default_nettype none

package xcrc_pkg;

    // Protocol bytes
    localparam logic [7:0] BYTE_SOH    = 8'h01;
    localparam logic [7:0] BYTE_STX    = 8'h02;
    localparam logic [7:0] BYTE_EOT    = 8'h04;
    localparam logic [7:0] BYTE_ACK    = 8'h06;
    localparam logic [7:0] BYTE_NAK    = 8'h15;
    localparam logic [7:0] BYTE_CAN    = 8'h18;
    localparam logic [7:0] BYTE_C      = 8'h43;
    localparam logic [7:0] BYTE_INVERT = 8'hff;

    // CRC-16 (CCITT polynomial, init zero, high byte first)
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] CRC_TOPBIT = 16'h8000;

    // Block geometry
    localparam int          POS_W       = 11;
    localparam logic [10:0] BLOCK_SMALL = 11'd128;
    localparam logic [10:0] BLOCK_LARGE = 11'd1024;

    // Configuration
    localparam int          CFG_IDX_W         = 1;
    localparam int          CFG_DATA_W        = 32;
    localparam logic [3:0]  ERROR_LIMIT_RESET = 4'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOTAL_LENGTH = 1'b0,
        CFG_ERROR_LIMIT  = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_START   = 2'd0,
        KIND_BYTE    = 2'd1,
        KIND_TIMEOUT = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        VERDICT_NONE   = 2'd0,
        VERDICT_COMMIT = 2'd1,
        VERDICT_DROP   = 2'd2
    } t_verdict;

    typedef enum logic [2:0] {
        ST_RUNNING   = 3'd0,
        ST_OK        = 3'd1,
        ST_SHORT     = 3'd2,
        ST_NO_SENDER = 3'd3,
        ST_BLK_TMO   = 3'd4,
        ST_BAD_BLK   = 3'd5,
        ST_CANCELLED = 3'd6
    } t_status;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic        reply_valid;
        logic [7:0]  reply_byte;
        logic        data_valid;
        logic [7:0]  data_byte;
        logic [1:0]  block_verdict;
        logic        done_res;
        logic [2:0]  status;
        logic [31:0] bytes_received;
    } t_result;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // Fold one byte into the running CRC, one bit per step
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOPBIT) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/xcrc_if.sv
// ============================================================================
// xcrc_if: channel interfaces of the XMODEM-CRC receiver
// Event input channel, result output channel and configuration write
// channel, each with valid/ready and its payload.
// ============================================================================
`default_nettype none

interface xcrc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] rx_byte;

    modport source (output valid, kind, rx_byte, input ready);
    modport sink   (input valid, kind, rx_byte, output ready);
endinterface

interface xcrc_out_if;
    logic        valid;
    logic        ready;
    logic        reply_valid;
    logic [7:0]  reply_byte;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [1:0]  block_verdict;
    logic        done_res;
    logic [2:0]  status;
    logic [31:0] bytes_received;

    modport source (output valid, reply_valid, reply_byte, data_valid, data_byte,
                    block_verdict, done_res, status, bytes_received,
                    input ready);
    modport sink   (input valid, reply_valid, reply_byte, data_valid, data_byte,
                    block_verdict, done_res, status, bytes_received,
                    output ready);
endinterface

interface xcrc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [xcrc_pkg::CFG_IDX_W-1:0]   index;
    logic [xcrc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/xcrc_in_reg.sv
// ============================================================================
// xcrc_in_reg: input register stage
// Captures one event per transfer and holds it until the engine consumes it.
// ============================================================================
`default_nettype none

module xcrc_in_reg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire xcrc_pkg::t_item i_item,
    output logic               o_ready,
    input  wire logic          i_free,
    output logic               o_valid,
    output xcrc_pkg::t_item    o_item
);

    logic            r_valid;
    xcrc_pkg::t_item r_item;
    logic            take;

    // Accept when empty or when the held event moves on this cycle
    assign o_ready = !r_valid || i_free;
    assign take    = i_valid && o_ready;

    // Hold valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_free) begin
            r_valid <= 1'b0;
        end
    end

    // Capture payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

### rtl/xcrc_out_reg.sv
// ============================================================================
// xcrc_out_reg: result register stage
// Holds a finished result until the sink takes it; frees itself in the same
// cycle the sink accepts, so a new result can land every cycle while it does.
// ============================================================================
`default_nettype none

module xcrc_out_reg (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_adv,
    input  wire xcrc_pkg::t_result i_res,
    output logic                 o_free,
    output logic                 o_valid,
    output xcrc_pkg::t_result    o_res,
    input  wire logic            i_ready
);

    logic              r_valid;
    xcrc_pkg::t_result r_res;

    assign o_free = !r_valid || i_ready;

    // Hold valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Capture result
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

### rtl/xcrc_engine.sv
// ============================================================================
// xcrc_engine: receiver protocol engine
// Holds the transfer state and configuration registers and computes the
// result of one event in a single combinational pass.
// ============================================================================
`default_nettype none

module xcrc_engine (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire xcrc_pkg::t_cfg_wr i_cfg,
    input  wire logic              i_adv,
    input  wire xcrc_pkg::t_item   i_item,
    output xcrc_pkg::t_result      o_res
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_HEAD  = 2'd1,
        PH_BLOCK = 2'd2
    } t_phase;

    // Configuration
    logic [31:0] r_total_length;
    logic [3:0]  r_error_limit;

    // Transfer state
    t_phase      r_phase,        n_phase;
    logic        r_large,        n_large;
    logic [10:0] r_pos,          n_pos;
    logic [7:0]  r_block_number, n_block_number;
    logic        r_num_ok,       n_num_ok;
    logic [15:0] r_crc,          n_crc;
    logic [7:0]  r_crc_high,     n_crc_high;
    logic [7:0]  r_expected,     n_expected;
    logic [3:0]  r_err,          n_err;
    logic [31:0] r_committed,    n_committed;
    logic [10:0] r_take,         n_take;

    // Helpers
    logic [7:0]  b;
    logic [10:0] size;
    logic [31:0] left;
    logic [10:0] take_new;
    logic [15:0] crc_next;
    logic [4:0]  err_inc;
    logic        err_fail;
    logic [10:0] pos_m2;
    xcrc_pkg::t_result res;

    assign b        = i_item.rx_byte;
    assign size     = r_large ? xcrc_pkg::BLOCK_LARGE : xcrc_pkg::BLOCK_SMALL;
    assign left     = r_total_length - r_committed;
    assign take_new = (left < {21'd0, size}) ? left[10:0] : size;
    assign crc_next = xcrc_pkg::crc16_byte(r_crc, b);
    assign err_inc  = {1'b0, r_err} + 5'd1;
    assign err_fail = err_inc > {1'b0, r_error_limit};
    assign pos_m2   = r_pos - 11'd2;

    // Compute next state and the result of the current event
    always_comb begin
        n_phase        = r_phase;
        n_large        = r_large;
        n_pos          = r_pos;
        n_block_number = r_block_number;
        n_num_ok       = r_num_ok;
        n_crc          = r_crc;
        n_crc_high     = r_crc_high;
        n_expected     = r_expected;
        n_err          = r_err;
        n_committed    = r_committed;
        n_take         = r_take;
        res            = '0;

        unique case (i_item.kind)
            xcrc_pkg::KIND_START: begin
                if (r_phase == PH_BLOCK) begin
                    res.block_verdict = xcrc_pkg::VERDICT_DROP;
                end
                n_phase         = PH_HEAD;
                n_expected      = 8'd1;
                n_err           = 4'd0;
                n_committed     = 32'd0;
                n_take          = 11'd0;
                n_pos           = 11'd0;
                res.reply_valid = 1'b1;
                res.reply_byte  = xcrc_pkg::BYTE_C;
            end
            xcrc_pkg::KIND_BYTE: begin
                if (r_phase == PH_HEAD) begin
                    // Look for a header, EOT or CAN; drop anything else
                    priority if (b == xcrc_pkg::BYTE_EOT) begin
                        res.reply_valid = 1'b1;
                        res.reply_byte  = xcrc_pkg::BYTE_ACK;
                        res.done_res    = 1'b1;
                        res.status      = (r_committed == r_total_length) ?
                                          xcrc_pkg::ST_OK : xcrc_pkg::ST_SHORT;
                        n_phase         = PH_IDLE;
                    end else if (b == xcrc_pkg::BYTE_CAN) begin
                        res.done_res = 1'b1;
                        res.status   = xcrc_pkg::ST_CANCELLED;
                        n_phase      = PH_IDLE;
                    end else if (b == xcrc_pkg::BYTE_SOH || b == xcrc_pkg::BYTE_STX) begin
                        n_phase  = PH_BLOCK;
                        n_large  = (b == xcrc_pkg::BYTE_STX);
                        n_pos    = 11'd0;
                        n_crc    = 16'h0000;
                        n_num_ok = 1'b0;
                        n_take   = 11'd0;
                    end else begin
                    end
                end else if (r_phase == PH_BLOCK) begin
                    // Walk through number, complement, data and CRC
                    priority if (r_pos == 11'd0) begin
                        n_block_number = b;
                        n_take         = (b == r_expected) ? take_new : 11'd0;
                    end else if (r_pos == 11'd1) begin
                        n_num_ok = ((b ^ xcrc_pkg::BYTE_INVERT) == r_block_number);
                    end else if (r_pos < size + 11'd2) begin
                        n_crc = crc_next;
                        if (pos_m2 < r_take) begin
                            res.data_valid = 1'b1;
                            res.data_byte  = b;
                        end
                    end else if (r_pos == size + 11'd2) begin
                        n_crc_high = b;
                    end else begin
                        if (r_num_ok && ({r_crc_high, b} == r_crc)) begin
                            if (r_block_number == r_expected) begin
                                n_committed = r_committed + {21'd0, r_take};
                                n_expected  = r_expected + 8'd1;
                                n_err       = 4'd0;
                            end
                            res.block_verdict = xcrc_pkg::VERDICT_COMMIT;
                            res.reply_valid   = 1'b1;
                            res.reply_byte    = xcrc_pkg::BYTE_ACK;
                            n_phase           = PH_HEAD;
                        end else begin
                            res.block_verdict = xcrc_pkg::VERDICT_DROP;
                            if (err_fail) begin
                                res.done_res = 1'b1;
                                res.status   = xcrc_pkg::ST_BAD_BLK;
                                n_phase      = PH_IDLE;
                            end else begin
                                n_err           = err_inc[3:0];
                                res.reply_valid = 1'b1;
                                res.reply_byte  = xcrc_pkg::BYTE_NAK;
                                n_phase         = PH_HEAD;
                            end
                        end
                    end
                    n_pos = r_pos + 11'd1;
                end
            end
            xcrc_pkg::KIND_TIMEOUT: begin
                if (r_phase == PH_HEAD) begin
                    if (err_fail) begin
                        res.done_res = 1'b1;
                        res.status   = xcrc_pkg::ST_NO_SENDER;
                        n_phase      = PH_IDLE;
                    end else begin
                        n_err           = err_inc[3:0];
                        res.reply_valid = 1'b1;
                        res.reply_byte  = (r_committed != 32'd0) ?
                                          xcrc_pkg::BYTE_NAK : xcrc_pkg::BYTE_C;
                    end
                end else if (r_phase == PH_BLOCK) begin
                    res.block_verdict = xcrc_pkg::VERDICT_DROP;
                    if (err_fail) begin
                        res.done_res = 1'b1;
                        res.status   = xcrc_pkg::ST_BLK_TMO;
                        n_phase      = PH_IDLE;
                    end else begin
                        n_err           = err_inc[3:0];
                        res.reply_valid = 1'b1;
                        res.reply_byte  = xcrc_pkg::BYTE_NAK;
                        n_phase         = PH_HEAD;
                    end
                end
            end
            default: begin
            end
        endcase

        res.bytes_received = n_committed;
    end

    assign o_res = res;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_length <= 32'd0;
            r_error_limit  <= xcrc_pkg::ERROR_LIMIT_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                xcrc_pkg::CFG_TOTAL_LENGTH: r_total_length <= i_cfg.data;
                xcrc_pkg::CFG_ERROR_LIMIT:  r_error_limit  <= i_cfg.data[3:0];
            endcase
        end
    end

    // Advance transfer state once per consumed event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_large        <= 1'b0;
            r_pos          <= 11'd0;
            r_block_number <= 8'd0;
            r_num_ok       <= 1'b0;
            r_crc          <= 16'h0000;
            r_crc_high     <= 8'd0;
            r_expected     <= 8'd1;
            r_err          <= 4'd0;
            r_committed    <= 32'd0;
            r_take         <= 11'd0;
        end else if (i_adv) begin
            r_phase        <= n_phase;
            r_large        <= n_large;
            r_pos          <= n_pos;
            r_block_number <= n_block_number;
            r_num_ok       <= n_num_ok;
            r_crc          <= n_crc;
            r_crc_high     <= n_crc_high;
            r_expected     <= n_expected;
            r_err          <= n_err;
            r_committed    <= n_committed;
            r_take         <= n_take;
        end
    end

    // A finished transfer leaves the engine idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && res.done_res) |=> (r_phase == PH_IDLE))
        else $error("transfer end did not return to idle");

    // Data bytes only come out of a block
    a_data_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && res.data_valid) |-> (r_phase == PH_BLOCK))
        else $error("data byte outside a block");

    // A commit always goes with an ACK
    a_commit_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.block_verdict == xcrc_pkg::VERDICT_COMMIT) |->
        (res.reply_valid && res.reply_byte == xcrc_pkg::BYTE_ACK))
        else $error("commit verdict without ACK");

    // Block position never runs past the last CRC byte
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BLOCK) |-> (r_pos <= size + 11'd3))
        else $error("block position past end of block");

endmodule

`default_nettype wire

### rtl/xmodem_crc_receiver_core.sv
// Throughput: 1 event per cycle while the result channel accepts; each event
// takes one pass through the engine from the input register to the result
// register, which holds its result for the output channel.
// The output register frees itself in the cycle its result is taken.
// Reset (synchronous, active low) empties both stages, returns the engine to
// idle and sets total_length to 0 and error_limit to 10.
// ============================================================================
// xmodem_crc_receiver_core: XMODEM-CRC / XMODEM-1K receiver top level
// Takes start, byte and timeout events, produces one result per event with
// reply, tentative data, block verdict and transfer status.
// ============================================================================
`default_nettype none

module xmodem_crc_receiver_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    xcrc_in_if.sink    i_item,
    xcrc_out_if.source o_res,
    xcrc_cfg_if.sink   i_cfg
);

    xcrc_pkg::t_item   in_item;
    xcrc_pkg::t_item   st_item;
    xcrc_pkg::t_result eng_res;
    xcrc_pkg::t_result out_res;
    xcrc_pkg::t_cfg_wr cfg_wr;
    logic              st_valid;
    logic              out_free;
    logic              adv;

    // Pack channel payloads
    assign in_item.kind    = i_item.kind;
    assign in_item.rx_byte = i_item.rx_byte;

    assign i_cfg.ready  = 1'b1;
    assign cfg_wr.valid = i_cfg.valid;
    assign cfg_wr.index = i_cfg.index;
    assign cfg_wr.data  = i_cfg.data;

    // Consume the held event when the result register can take its result
    assign adv = st_valid && out_free;

    xcrc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_item.valid),
        .i_item  (in_item),
        .o_ready (i_item.ready),
        .i_free  (out_free),
        .o_valid (st_valid),
        .o_item  (st_item)
    );

    xcrc_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_wr),
        .i_adv   (adv),
        .i_item  (st_item),
        .o_res   (eng_res)
    );

    xcrc_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_res   (eng_res),
        .o_free  (out_free),
        .o_valid (o_res.valid),
        .o_res   (out_res),
        .i_ready (o_res.ready)
    );

    // Unpack result payload
    assign o_res.reply_valid    = out_res.reply_valid;
    assign o_res.reply_byte     = out_res.reply_byte;
    assign o_res.data_valid     = out_res.data_valid;
    assign o_res.data_byte      = out_res.data_byte;
    assign o_res.block_verdict  = out_res.block_verdict;
    assign o_res.done_res       = out_res.done_res;
    assign o_res.status         = out_res.status;
    assign o_res.bytes_received = out_res.bytes_received;

endmodule

`default_nettype wire

### dv/xcrc_rx_checker.sv
// ============================================================================
// xcrc_rx_checker: result checker for the XMODEM-CRC receiver
// Watches the event, result and configuration channels, runs its own model
// of the receive protocol on every event transfer, queues the predicted
// results and compares each result transfer field by field with the oldest.
// ============================================================================
`default_nettype none

module xcrc_rx_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    xcrc_in_if        i_item,
    xcrc_out_if       i_res,
    xcrc_cfg_if       i_cfg,
    output int        o_faults,
    output int        o_pending
);

    typedef enum logic [1:0] {
        LINK_IDLE   = 2'd0,
        LINK_HEADER = 2'd1,
        LINK_BLOCK  = 2'd2
    } t_link;

    // Register copies
    logic [31:0] total_len;
    logic [3:0]  err_limit;

    // Protocol state
    t_link       link;
    logic        big_block;
    logic [10:0] blk_pos;
    logic [7:0]  blk_num;
    logic        num_ok;
    logic [15:0] crc_acc;
    logic [7:0]  crc_high;
    logic [7:0]  next_number;
    logic [3:0]  err_count;
    logic [31:0] committed;
    logic [10:0] take;

    xcrc_pkg::t_result awaited_results[$];
    int                faults = 0;

    // CRC-16 update, shifting the message in from its top bit
    function automatic logic [15:0] crc_fold(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = acc;
        for (int k = 7; k >= 0; k--) begin
            fb = c[15] ^ b[k];
            c  = {c[14:0], 1'b0} ^ (fb ? xcrc_pkg::CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    // Bump the error count; report when the limit is passed (count then kept)
    function automatic bit error_limit_hit();
        logic [4:0] n;
        n = {1'b0, err_count} + 5'd1;
        if (n > {1'b0, err_limit}) begin
            return 1'b1;
        end
        err_count = n[3:0];
        return 1'b0;
    endfunction

    // Advance the receive protocol by one event and return its result
    function automatic xcrc_pkg::t_result advance_receiver(input logic [1:0] kind,
                                                           input logic [7:0] b);
        xcrc_pkg::t_result r;
        logic [10:0]       size;
        logic [10:0]       pos;
        logic [31:0]       left;
        r    = '0;
        size = big_block ? xcrc_pkg::BLOCK_LARGE : xcrc_pkg::BLOCK_SMALL;
        pos  = blk_pos;
        if (kind == xcrc_pkg::KIND_START) begin
            // restart; tentative bytes of an open block are dropped
            if (link == LINK_BLOCK) begin
                r.block_verdict = xcrc_pkg::VERDICT_DROP;
            end
            link          = LINK_HEADER;
            next_number   = 8'd1;
            err_count     = 4'd0;
            committed     = 32'd0;
            take          = 11'd0;
            blk_pos       = 11'd0;
            r.reply_valid = 1'b1;
            r.reply_byte  = xcrc_pkg::BYTE_C;
        end else if (kind == xcrc_pkg::KIND_BYTE && link == LINK_HEADER) begin
            if (b == xcrc_pkg::BYTE_EOT) begin
                r.reply_valid = 1'b1;
                r.reply_byte  = xcrc_pkg::BYTE_ACK;
                r.done_res    = 1'b1;
                r.status      = (committed == total_len) ?
                                xcrc_pkg::ST_OK : xcrc_pkg::ST_SHORT;
                link          = LINK_IDLE;
            end else if (b == xcrc_pkg::BYTE_CAN) begin
                r.done_res = 1'b1;
                r.status   = xcrc_pkg::ST_CANCELLED;
                link       = LINK_IDLE;
            end else if (b == xcrc_pkg::BYTE_SOH || b == xcrc_pkg::BYTE_STX) begin
                link      = LINK_BLOCK;
                big_block = (b == xcrc_pkg::BYTE_STX);
                blk_pos   = 11'd0;
                crc_acc   = 16'h0000;
                num_ok    = 1'b0;
                take      = 11'd0;
            end
        end else if (kind == xcrc_pkg::KIND_BYTE && link == LINK_BLOCK) begin
            if (pos == 11'd0) begin
                // block number; decide how many data bytes go out
                left    = total_len - committed;
                blk_num = b;
                if (b != next_number) begin
                    take = 11'd0;
                end else if (left < {21'd0, size}) begin
                    take = left[10:0];
                end else begin
                    take = size;
                end
            end else if (pos == 11'd1) begin
                num_ok = ((b ^ xcrc_pkg::BYTE_INVERT) == blk_num);
            end else if (pos < size + 11'd2) begin
                crc_acc = crc_fold(crc_acc, b);
                if (pos - 11'd2 < take) begin
                    r.data_valid = 1'b1;
                    r.data_byte  = b;
                end
            end else if (pos == size + 11'd2) begin
                crc_high = b;
            end else if (num_ok && {crc_high, b} == crc_acc) begin
                // good block: only the expected number adds bytes
                if (blk_num == next_number) begin
                    committed   = committed + {21'd0, take};
                    next_number = next_number + 8'd1;
                    err_count   = 4'd0;
                end
                r.block_verdict = xcrc_pkg::VERDICT_COMMIT;
                r.reply_valid   = 1'b1;
                r.reply_byte    = xcrc_pkg::BYTE_ACK;
                link            = LINK_HEADER;
            end else begin
                r.block_verdict = xcrc_pkg::VERDICT_DROP;
                if (error_limit_hit()) begin
                    r.done_res = 1'b1;
                    r.status   = xcrc_pkg::ST_BAD_BLK;
                    link       = LINK_IDLE;
                end else begin
                    r.reply_valid = 1'b1;
                    r.reply_byte  = xcrc_pkg::BYTE_NAK;
                    link          = LINK_HEADER;
                end
            end
            blk_pos = pos + 11'd1;
        end else if (kind == xcrc_pkg::KIND_TIMEOUT && link == LINK_HEADER) begin
            if (error_limit_hit()) begin
                r.done_res = 1'b1;
                r.status   = xcrc_pkg::ST_NO_SENDER;
                link       = LINK_IDLE;
            end else begin
                r.reply_valid = 1'b1;
                r.reply_byte  = (committed != 32'd0) ? xcrc_pkg::BYTE_NAK : xcrc_pkg::BYTE_C;
            end
        end else if (kind == xcrc_pkg::KIND_TIMEOUT && link == LINK_BLOCK) begin
            r.block_verdict = xcrc_pkg::VERDICT_DROP;
            if (error_limit_hit()) begin
                r.done_res = 1'b1;
                r.status   = xcrc_pkg::ST_BLK_TMO;
                link       = LINK_IDLE;
            end else begin
                r.reply_valid = 1'b1;
                r.reply_byte  = xcrc_pkg::BYTE_NAK;
                link          = LINK_HEADER;
            end
        end
        r.bytes_received = committed;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            faults++;
            if (faults <= 10) begin
                $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
            end
        end
    endtask

    // Track configuration, compare results, queue predictions
    always @(posedge i_clk) begin
        xcrc_pkg::t_result want;
        xcrc_pkg::t_result seen;
        if (!i_rst_n) begin
            total_len   = 32'd0;
            err_limit   = xcrc_pkg::ERROR_LIMIT_RESET;
            link        = LINK_IDLE;
            big_block   = 1'b0;
            blk_pos     = 11'd0;
            blk_num     = 8'd0;
            num_ok      = 1'b0;
            crc_acc     = 16'h0000;
            crc_high    = 8'd0;
            next_number = 8'd1;
            err_count   = 4'd0;
            committed   = 32'd0;
            take        = 11'd0;
            awaited_results.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == xcrc_pkg::CFG_TOTAL_LENGTH) begin
                    total_len = i_cfg.data;
                end else begin
                    err_limit = i_cfg.data[3:0];
                end
            end
            // compare first: a result never belongs to an event of this cycle
            if (i_res.valid && i_res.ready) begin
                seen.reply_valid    = i_res.reply_valid;
                seen.reply_byte     = i_res.reply_byte;
                seen.data_valid     = i_res.data_valid;
                seen.data_byte      = i_res.data_byte;
                seen.block_verdict  = i_res.block_verdict;
                seen.done_res       = i_res.done_res;
                seen.status         = i_res.status;
                seen.bytes_received = i_res.bytes_received;
                if (awaited_results.size() == 0) begin
                    faults++;
                    if (faults <= 10) begin
                        $display("%0t: result transfer with none outstanding", $time);
                    end
                end else begin
                    want = awaited_results.pop_front();
                    check_field("reply_valid", want.reply_valid, seen.reply_valid);
                    check_field("reply_byte", want.reply_byte, seen.reply_byte);
                    check_field("data_valid", want.data_valid, seen.data_valid);
                    check_field("data_byte", want.data_byte, seen.data_byte);
                    check_field("block_verdict", want.block_verdict, seen.block_verdict);
                    check_field("done_res", want.done_res, seen.done_res);
                    check_field("status", want.status, seen.status);
                    check_field("bytes_received", want.bytes_received, seen.bytes_received);
                end
            end
            if (i_item.valid && i_item.ready) begin
                awaited_results.push_back(advance_receiver(i_item.kind, i_item.rx_byte));
            end
        end
        o_faults  <= faults;
        o_pending <= awaited_results.size();
    end

endmodule

`default_nettype wire

### dv/testbench.sv
// ============================================================================
// testbench: stimulus and verdict for xmodem_crc_receiver_core
// Drives start, byte and timeout events through directed corner cases and
// randomized file transfers made of good, broken and cut-short blocks, with
// random gaps on both channels and register changes between and within transfers.
// ============================================================================
`default_nettype none

module testbench;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         WHOLE_BLOCK = 2048;
    localparam int         QUIET_LIMIT = 2000;
    localparam int         ITEM_GOAL   = 550;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int events_sent   = 0;
    int quiet_cycles  = 0;
    int fault_total;
    int pending_results;

    xcrc_in_if  item_ch();
    xcrc_out_if res_ch();
    xcrc_cfg_if cfg_ch();

    xmodem_crc_receiver_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    xcrc_rx_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (item_ch),
        .i_res     (res_ch),
        .i_cfg     (cfg_ch),
        .o_faults  (fault_total),
        .o_pending (pending_results)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Randomly stall the result channel
    always @(posedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // End the run when no transfer of any kind happens for too long
    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("xmodem_crc_receiver_core: mismatch");
            $finish;
        end
    end

    // Offer one event, sometimes after a random gap; returns on its transfer edge
    task automatic send_event(input logic [1:0] kind, input logic [7:0] value);
        if ($urandom_range(99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.kind    <= kind;
        item_ch.rx_byte <= value;
        @(negedge i_clk);
        while (!item_ch.ready) @(negedge i_clk);
        @(posedge i_clk);
        events_sent++;
    endtask

    // Hold off events until every outstanding result has been taken
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending_results != 0) @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write both registers back to back; only called while idle
    task automatic set_config(input logic [31:0] length, input logic [3:0] limit);
        cfg_ch.valid <= 1'b1;
        for (int r = 0; r < 2; r++) begin
            cfg_ch.index <= (r == 0) ? xcrc_pkg::CFG_TOTAL_LENGTH : xcrc_pkg::CFG_ERROR_LIMIT;
            cfg_ch.data  <= (r == 0) ? length : {28'd0, limit};
            @(negedge i_clk);
            while (!cfg_ch.ready) @(negedge i_clk);
            @(posedge i_clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // Header, number, complement, random data and CRC; stop after cut body bytes
    task automatic send_block(input bit big, input logic [7:0] number,
                              input logic [7:0] inverse, input bit bad_crc, input int cut);
        int          size;
        logic [15:0] crc;
        logic [7:0]  payload;
        size = big ? 1024 : 128;
        crc  = 16'h0000;
        send_event(xcrc_pkg::KIND_BYTE, big ? xcrc_pkg::BYTE_STX : xcrc_pkg::BYTE_SOH);
        for (int j = 0; j < size + 4; j++) begin
            if (j == cut) begin
                return;
            end
            if (j == 0) begin
                payload = number;
            end else if (j == 1) begin
                payload = inverse;
            end else if (j < size + 2) begin
                payload = 8'($urandom);
                crc     = xcrc_pkg::crc16_byte(crc, payload);
            end else if (j == size + 2) begin
                payload = crc[15:8];
            end else begin
                payload = crc[7:0] ^ (bad_crc ? 8'(1 << $urandom_range(7)) : 8'h00);
            end
            send_event(xcrc_pkg::KIND_BYTE, payload);
        end
    endtask

    // One randomized transfer: new settings, start, one or two blocks, an ending
    task automatic run_transfer(input bit with_large);
        int          blocks;
        int          mode;
        int          ending;
        logic [7:0]  number;
        logic [7:0]  other;
        logic [7:0]  noise;
        logic [31:0] length;
        logic [3:0]  limit;
        blocks = $urandom_range(1, 2);
        if (with_large) begin
            length = $urandom_range(900, 1200);
        end else begin
            case ($urandom_range(9))
                0:       length = 32'd0;
                1:       length = 32'hffff_ffff;
                2:       length = $urandom();
                3, 4, 5: length = blocks * 128 - $urandom_range(0, 127);
                default: length = $urandom_range(0, 600);
            endcase
        end
        case ($urandom_range(5))
            0:       limit = 4'd0;
            1:       limit = 4'd15;
            default: limit = 4'($urandom_range(0, 15));
        endcase
        wait_idle();
        set_config(length, limit);

        // stray events while idle are dropped by the block
        if ($urandom_range(3) == 0) begin
            send_event(2'($urandom_range(1, 3)), 8'($urandom));
        end
        send_event(xcrc_pkg::KIND_START, 8'($urandom));
        number = 8'd1;
        for (int i = 0; i < blocks; i++) begin
            mode = $urandom_range(99);
            if (with_large && i == 0) begin
                // open a large block, stop partway and let it time out
                send_block(1'b1, number, ~number, 1'b0, $urandom_range(2, 160));
                send_event(xcrc_pkg::KIND_TIMEOUT, 8'($urandom));
            end else if (mode < 62) begin
                send_block(1'b0, number, ~number, 1'b0, WHOLE_BLOCK);
                number++;
            end else if (mode < 68) begin
                send_block(1'b0, number, ~number ^ 8'(1 << $urandom_range(7)), 1'b0,
                           WHOLE_BLOCK);
            end else if (mode < 74) begin
                send_block(1'b0, number, ~number, 1'b1, WHOLE_BLOCK);
            end else if (mode < 79) begin
                other = $urandom_range(1) ? number - 8'd1 : 8'($urandom);
                send_block(1'b0, other, ~other, 1'b0, WHOLE_BLOCK);
            end else if (mode < 85) begin
                send_block(1'b0, number, ~number, 1'b0, $urandom_range(0, 131));
                send_event(xcrc_pkg::KIND_TIMEOUT, 8'($urandom));
            end else if (mode < 91) begin
                send_event(xcrc_pkg::KIND_TIMEOUT, 8'($urandom));
            end else if (mode < 95) begin
                do noise = 8'($urandom);
                while (noise inside {xcrc_pkg::BYTE_SOH, xcrc_pkg::BYTE_STX,
                                     xcrc_pkg::BYTE_EOT, xcrc_pkg::BYTE_CAN});
                send_event(xcrc_pkg::KIND_BYTE, noise);
            end else begin
                // restart in the middle of a block
                send_block(1'($urandom_range(1)), number, ~number, 1'b0,
                           $urandom_range(0, 100));
                send_event(xcrc_pkg::KIND_START, 8'($urandom));
                number = 8'd1;
            end
            if ($urandom_range(19) == 0) begin
                wait_idle();
            end
        end

        ending = $urandom_range(99);
        if (ending < 75) begin
            send_event(xcrc_pkg::KIND_BYTE, xcrc_pkg::BYTE_EOT);
        end else if (ending < 88) begin
            send_event(xcrc_pkg::KIND_BYTE, xcrc_pkg::BYTE_CAN);
        end else begin
            repeat (limit + 2) send_event(xcrc_pkg::KIND_TIMEOUT, 8'($urandom));
        end
    endtask

    initial begin : stimulus
        int goal;
        item_ch.valid   = 1'b0;
        item_ch.kind    = xcrc_pkg::KIND_START;
        item_ch.rx_byte = 8'd0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = xcrc_pkg::CFG_TOTAL_LENGTH;
        cfg_ch.data     = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_config(32'd0, 4'd10);

        // Directed corner cases
        send_event(xcrc_pkg::KIND_BYTE, 8'hff);
        send_event(xcrc_pkg::KIND_TIMEOUT, 8'h00);
        send_event(KIND_UNUSED, 8'haa);
        send_event(xcrc_pkg::KIND_START, 8'h00);
        send_event(xcrc_pkg::KIND_TIMEOUT, 8'h00);
        send_event(xcrc_pkg::KIND_BYTE, 8'h55);
        send_event(KIND_UNUSED, 8'h00);
        send_event(xcrc_pkg::KIND_BYTE, xcrc_pkg::BYTE_SOH);
        send_event(xcrc_pkg::KIND_BYTE, 8'h01);
        send_event(xcrc_pkg::KIND_BYTE, 8'hfe);
        send_event(xcrc_pkg::KIND_TIMEOUT, 8'hff);
        send_event(xcrc_pkg::KIND_BYTE, xcrc_pkg::BYTE_STX);
        send_event(xcrc_pkg::KIND_BYTE, 8'h01);
        send_event(xcrc_pkg::KIND_START, 8'hff);
        send_event(xcrc_pkg::KIND_BYTE, xcrc_pkg::BYTE_EOT);
        send_event(xcrc_pkg::KIND_START, 8'h00);
        send_event(xcrc_pkg::KIND_BYTE, xcrc_pkg::BYTE_CAN);
        wait_idle();
        set_config(32'hffff_ffff, 4'd0);
        send_event(xcrc_pkg::KIND_START, 8'h00);
        send_event(xcrc_pkg::KIND_TIMEOUT, 8'h00);
        send_event(xcrc_pkg::KIND_START, 8'h00);
        send_event(xcrc_pkg::KIND_BYTE, xcrc_pkg::BYTE_EOT);
        send_event(xcrc_pkg::KIND_START, 8'h00);
        send_event(xcrc_pkg::KIND_BYTE, xcrc_pkg::BYTE_SOH);
        send_event(xcrc_pkg::KIND_TIMEOUT, 8'h00);

        // Random transfers under three idling patterns
        for (int p = 0; p < 3; p++) begin
            send_idle_pct = (p == 0) ? 38 : (p == 1) ? 45 : 0;
            recv_idle_pct = (p == 0) ? 45 : (p == 1) ? 38 : 0;
            if (p == 0) begin
                // shrink the length below the committed count mid-transfer
                wait_idle();
                set_config(32'd200, 4'd15);
                send_event(xcrc_pkg::KIND_START, 8'h00);
                send_block(1'b0, 8'd1, 8'hfe, 1'b0, WHOLE_BLOCK);
                wait_idle();
                set_config(32'd50, 4'd15);
                send_block(1'b0, 8'd2, 8'hfd, 1'b0, WHOLE_BLOCK);
                send_event(xcrc_pkg::KIND_BYTE, xcrc_pkg::BYTE_EOT);
            end
            goal = ITEM_GOAL * (p + 1) / 3;
            if (p == 2) begin
                run_transfer(1'b1);
            end
            while (events_sent < goal) begin
                run_transfer(1'b0);
            end
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (fault_total == 0 && pending_results == 0) begin
            $display("xmodem_crc_receiver_core: match");
        end else begin
            $display("xmodem_crc_receiver_core: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
